@@ rtl/slt_pkg.sv @@
// Shared types and constants for the slot table allocator.
// Used by the channel interfaces and every module of the block but slt_ram; depends on nothing.
package slt_pkg;

    localparam int SLOT_COUNT_DEF  = 1024;
    localparam int VALUE_WIDTH_DEF = 64;

    localparam int ACT_W      = 2;
    localparam int IDX_W      = 10;
    localparam int VAL_PORT_W = 64;
    localparam int ERR_W      = 2;

    localparam int ROW_W     = 32;
    localparam int ROW_BIT_W = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_SET   = 2'd2,
        ACT_GET   = 2'd3
    } action_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE    = 2'd0,
        ERR_INVALID = 2'd1,
        ERR_FULL    = 2'd2
    } err_t;

    typedef struct packed {
        logic                  ok;
        logic [IDX_W-1:0]      slot;
        logic [VAL_PORT_W-1:0] value;
        err_t                  err;
    } result_t;

    typedef struct packed {
        logic valid;
        logic full;
    } flag_upd_t;

endpackage

@@ rtl/slt_if.sv @@
// Request and response channel interfaces of the slot table allocator.
// Depends on slt_pkg for the field widths.
interface slt_req_if;
    logic                           valid;
    logic                           ready;
    logic [slt_pkg::ACT_W-1:0]      action;
    logic [slt_pkg::IDX_W-1:0]      slot_index;
    logic [slt_pkg::VAL_PORT_W-1:0] value_in;

    modport source (output valid, action, slot_index, value_in, input ready);
    modport sink (input valid, action, slot_index, value_in, output ready);
endinterface

interface slt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           ok;
    logic [slt_pkg::IDX_W-1:0]      slot_out;
    logic [slt_pkg::VAL_PORT_W-1:0] value_out;
    logic [slt_pkg::ERR_W-1:0]      error_code;

    modport source (output valid, ok, slot_out, value_out, error_code, input ready);
    modport sink (input valid, ok, slot_out, value_out, error_code, output ready);
endinterface

@@ rtl/slt_ram.sv @@
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Used for the busy bitmap rows and for the slot values; no dependencies.
module slt_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/slt_search.sv @@
// Row-full flags of the busy bitmap and a two-stage registered search for the
// lowest row that still has a free slot. Depends on slt_pkg.
module slt_search #(
    parameter int ROWS      = 32,
    parameter int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  slt_pkg::flag_upd_t       upd,
    input  logic [ROW_IDX_W-1:0]     upd_row,
    output logic                     found,
    output logic [ROW_IDX_W-1:0]     free_row
);

    localparam int GRP       = 8;
    localparam int POS_W     = $clog2(GRP);
    localparam int GROUPS    = (ROWS + GRP - 1) / GRP;
    localparam int GRP_IDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int PAD       = GROUPS * GRP;

    logic [ROWS-1:0]              full_reg;
    logic [PAD-1:0]               padded;
    logic [GROUPS-1:0]            grp_free;
    logic [POS_W-1:0]             grp_pos [GROUPS];
    logic [GROUPS-1:0]            grp_free_reg;
    logic [POS_W-1:0]             grp_pos_reg [GROUPS];
    logic                         found_next;
    logic [GRP_IDX_W+POS_W-1:0]   row_wide;
    logic                         found_reg;
    logic [ROW_IDX_W-1:0]         row_reg;

    always_comb
    begin
        padded = '1;
        padded[ROWS-1:0] = full_reg;
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_free[g] = ~&padded[g*GRP +: GRP];
            grp_pos[g]  = '0;
            for (int j = GRP - 1; j >= 0; j--)
            begin
                if (!padded[g*GRP + j])
                begin
                    grp_pos[g] = POS_W'(j);
                end
            end
        end
    end

    always_comb
    begin
        found_next = |grp_free_reg;
        row_wide   = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (grp_free_reg[g])
            begin
                row_wide = {GRP_IDX_W'(g), grp_pos_reg[g]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg     <= '0;
            grp_free_reg <= '0;
            grp_pos_reg  <= '{default: '0};
            found_reg    <= 1'b0;
            row_reg      <= '0;
        end
        else
        begin
            if (upd.valid)
            begin
                full_reg[upd_row] <= upd.full;
            end
            grp_free_reg <= grp_free;
            grp_pos_reg  <= grp_pos;
            found_reg    <= found_next;
            row_reg      <= row_wide[ROW_IDX_W-1:0];
        end
    end

    assign found    = found_reg;
    assign free_row = row_reg;

endmodule

@@ rtl/slt_ctrl.sv @@
// Request sequencer: decodes each request, reads and rewrites the bitmap and
// value memories, keeps the bump pointer and drives the response register.
// Depends on slt_pkg and the channel interfaces in slt_if.
module slt_ctrl #(
    parameter int SLOT_COUNT  = slt_pkg::SLOT_COUNT_DEF,
    parameter int VALUE_WIDTH = slt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    slt_req_if.sink              req,
    slt_rsp_if.source            rsp,
    output logic                 bm_we,
    output logic [((SLOT_COUNT + slt_pkg::ROW_W - 1) / slt_pkg::ROW_W > 1 ?
                   $clog2((SLOT_COUNT + slt_pkg::ROW_W - 1) / slt_pkg::ROW_W) : 1) - 1:0]
                                 bm_waddr,
    output logic [slt_pkg::ROW_W-1:0] bm_wdata,
    output logic [((SLOT_COUNT + slt_pkg::ROW_W - 1) / slt_pkg::ROW_W > 1 ?
                   $clog2((SLOT_COUNT + slt_pkg::ROW_W - 1) / slt_pkg::ROW_W) : 1) - 1:0]
                                 bm_raddr,
    input  logic [slt_pkg::ROW_W-1:0] bm_rdata,
    output logic                 vm_we,
    output logic [$clog2(SLOT_COUNT)-1:0] vm_waddr,
    output logic [VALUE_WIDTH-1:0] vm_wdata,
    output logic [$clog2(SLOT_COUNT)-1:0] vm_raddr,
    input  logic [VALUE_WIDTH-1:0] vm_rdata,
    output slt_pkg::flag_upd_t   upd,
    output logic [((SLOT_COUNT + slt_pkg::ROW_W - 1) / slt_pkg::ROW_W > 1 ?
                   $clog2((SLOT_COUNT + slt_pkg::ROW_W - 1) / slt_pkg::ROW_W) : 1) - 1:0]
                                 upd_row,
    input  logic                 srch_found,
    input  logic [((SLOT_COUNT + slt_pkg::ROW_W - 1) / slt_pkg::ROW_W > 1 ?
                   $clog2((SLOT_COUNT + slt_pkg::ROW_W - 1) / slt_pkg::ROW_W) : 1) - 1:0]
                                 srch_row
);

    localparam int RW        = slt_pkg::ROW_W;
    localparam int BW        = slt_pkg::ROW_BIT_W;
    localparam int ROWS      = (SLOT_COUNT + RW - 1) / RW;
    localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_W    = $clog2(SLOT_COUNT);
    localparam int SA_W      = ROW_IDX_W + BW;
    localparam int BUMP_W    = $clog2(SLOT_COUNT + 1);
    localparam int CMP_A     = (SA_W > BUMP_W) ? SA_W : BUMP_W;
    localparam int CMP_W     = (CMP_A > slt_pkg::IDX_W) ? CMP_A : slt_pkg::IDX_W;
    localparam int LAST_BITS = SLOT_COUNT - (ROWS - 1) * RW;

    localparam logic [RW-1:0] LAST_MASK = (LAST_BITS >= RW) ? {RW{1'b1}} :
                                          RW'((64'd1 << LAST_BITS) - 64'd1);
    localparam logic [ROW_IDX_W-1:0] LAST_ROW  = ROW_IDX_W'(ROWS - 1);
    localparam logic [BUMP_W-1:0]    BUMP_FULL = BUMP_W'(SLOT_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUMP,
        S_SRCH1,
        S_SRCH2,
        S_FIND,
        S_ACCESS,
        S_HOLD
    } state_t;

    state_t                   state_reg;
    logic [BUMP_W-1:0]        bump_reg;
    slt_pkg::action_t         act_reg;
    logic [CMP_W-1:0]         idx_reg;
    logic [VALUE_WIDTH-1:0]   val_reg;
    logic [ROW_IDX_W-1:0]     row_reg;
    logic [BW-1:0]            bit_reg;
    slt_pkg::result_t         res_reg;
    slt_pkg::result_t         out_reg;
    logic                     out_valid_reg;

    logic [CMP_W-1:0]         idx_ext;
    logic [CMP_W-1:0]         bump_ext;
    logic [CMP_W-1:0]         sel_ext;
    logic [CMP_W-1:0]         row_hi;
    logic [CMP_W-1:0]         bump_hi;
    logic [RW-1:0]            fill_mask;
    logic [RW-1:0]            range_mask;
    logic [RW-1:0]            row_live;
    logic [RW-1:0]            row_view;
    logic [BW-1:0]            find_bit;
    logic [BW-1:0]            wr_bit;
    logic [RW-1:0]            set_mask;
    logic [SA_W-1:0]          slot_sa;
    logic [CMP_W-1:0]         slot_wide;
    logic                     hit;
    logic                     done;
    logic                     out_free;
    logic                     out_load;
    slt_pkg::result_t         res_calc;

    assign idx_ext  = CMP_W'(req.slot_index);
    assign bump_ext = CMP_W'(bump_reg);
    assign sel_ext  = (req.action == slt_pkg::ACT_ALLOC) ? bump_ext : idx_ext;
    assign row_hi   = CMP_W'(row_reg);
    assign bump_hi  = bump_ext >> BW;

    // Bits at or above the bump pointer have never been written and read as free.
    always_comb
    begin
        if (row_hi < bump_hi)
        begin
            fill_mask = '1;
        end
        else if (row_hi == bump_hi)
        begin
            fill_mask = (RW'(1) << bump_ext[BW-1:0]) - RW'(1);
        end
        else
        begin
            fill_mask = '0;
        end
    end

    assign range_mask = (row_reg == LAST_ROW) ? LAST_MASK : '1;
    assign row_live   = bm_rdata & fill_mask;
    assign row_view   = row_live | ~range_mask;

    always_comb
    begin
        find_bit = '0;
        for (int i = RW - 1; i >= 0; i--)
        begin
            if (!row_view[i])
            begin
                find_bit = BW'(i);
            end
        end
    end

    assign wr_bit    = (state_reg == S_FIND) ? find_bit : bit_reg;
    assign set_mask  = RW'(1) << wr_bit;
    assign slot_sa   = {row_reg, wr_bit};
    assign slot_wide = CMP_W'(slot_sa);
    assign hit       = (idx_reg < bump_ext) && row_live[bit_reg];
    assign out_free  = !out_valid_reg || rsp.ready;
    assign out_load  = (done || (state_reg == S_HOLD)) && out_free;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  bm_raddr = sel_ext[BW +: ROW_IDX_W];
            S_SRCH2: bm_raddr = srch_row;
            default: bm_raddr = row_reg;
        endcase
    end

    assign vm_raddr = idx_ext[SLOT_W-1:0];
    assign bm_waddr = row_reg;
    assign upd_row  = row_reg;
    assign vm_waddr = (state_reg == S_ACCESS) ? idx_reg[SLOT_W-1:0] : slot_sa[SLOT_W-1:0];

    always_comb
    begin
        bm_we    = 1'b0;
        bm_wdata = row_live | set_mask;
        vm_we    = 1'b0;
        vm_wdata = '0;
        upd      = '0;
        done     = 1'b0;
        res_calc = '0;
        unique case (state_reg)
            S_BUMP, S_FIND:
            begin
                bm_we         = 1'b1;
                vm_we         = 1'b1;
                upd.valid     = 1'b1;
                upd.full      = &(row_view | set_mask);
                done          = 1'b1;
                res_calc.ok   = 1'b1;
                res_calc.slot = slot_wide[slt_pkg::IDX_W-1:0];
            end
            S_SRCH2:
            begin
                if (!srch_found)
                begin
                    done         = 1'b1;
                    res_calc.err = slt_pkg::ERR_FULL;
                end
            end
            S_ACCESS:
            begin
                done = 1'b1;
                if (!hit)
                begin
                    res_calc.err = slt_pkg::ERR_INVALID;
                end
                else
                begin
                    res_calc.ok = 1'b1;
                    unique case (act_reg)
                        slt_pkg::ACT_FREE:
                        begin
                            bm_we     = 1'b1;
                            bm_wdata  = row_live & ~set_mask;
                            upd.valid = 1'b1;
                            upd.full  = 1'b0;
                        end
                        slt_pkg::ACT_SET:
                        begin
                            vm_we    = 1'b1;
                            vm_wdata = val_reg;
                        end
                        slt_pkg::ACT_GET:
                        begin
                            res_calc.value = slt_pkg::VAL_PORT_W'(vm_rdata);
                        end
                        slt_pkg::ACT_ALLOC:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bump_reg      <= '0;
            act_reg       <= slt_pkg::ACT_ALLOC;
            idx_reg       <= '0;
            val_reg       <= '0;
            row_reg       <= '0;
            bit_reg       <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        act_reg <= slt_pkg::action_t'(req.action);
                        idx_reg <= idx_ext;
                        val_reg <= req.value_in[VALUE_WIDTH-1:0];
                        row_reg <= sel_ext[BW +: ROW_IDX_W];
                        bit_reg <= sel_ext[BW-1:0];
                        if (req.action != slt_pkg::ACT_ALLOC)
                        begin
                            state_reg <= S_ACCESS;
                        end
                        else if (bump_reg != BUMP_FULL)
                        begin
                            state_reg <= S_BUMP;
                        end
                        else
                        begin
                            state_reg <= S_SRCH1;
                        end
                    end
                end
                S_SRCH1:
                begin
                    state_reg <= S_SRCH2;
                end
                S_SRCH2:
                begin
                    if (srch_found)
                    begin
                        row_reg   <= srch_row;
                        state_reg <= S_FIND;
                    end
                end
                S_BUMP:
                begin
                    bump_reg <= bump_reg + BUMP_W'(1);
                end
                S_HOLD:
                begin
                    if (out_free)
                    begin
                        out_reg   <= res_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
            if (done)
            begin
                if (out_free)
                begin
                    out_reg   <= res_calc;
                    state_reg <= S_IDLE;
                end
                else
                begin
                    res_reg   <= res_calc;
                    state_reg <= S_HOLD;
                end
            end
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.ok         = out_reg.ok;
    assign rsp.slot_out   = out_reg.slot;
    assign rsp.value_out  = out_reg.value;
    assign rsp.error_code = out_reg.err;

endmodule

@@ rtl/slot_table_allocator.sv @@
// Slot table allocator: a table of SLOT_COUNT slots, each with a busy bit and a
// VALUE_WIDTH-bit value, served one request at a time through a request and a
// response channel. Busy bits live in a RAM of 32-bit rows and values in a second
// RAM, both with registered reads; each RAM is written at most once per request.
// Free, set, get and any alloc while the bump pointer is below SLOT_COUNT go
// through an access or bump state; once the bump pointer is exhausted an alloc
// runs a two-stage search over per-row full flags and then reads the chosen row,
// or answers full when no row is free. The next request is taken while the last
// response waits, and a stalled response adds the cycles it waits. The bump pointer
// also marks which memory entries hold data, so no clearing pass follows reset.
module slot_table_allocator #(
    parameter int SLOT_COUNT  = slt_pkg::SLOT_COUNT_DEF,
    parameter int VALUE_WIDTH = slt_pkg::VALUE_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    slt_req_if.sink   req,
    slt_rsp_if.source rsp
);

    localparam int ROWS      = (SLOT_COUNT + slt_pkg::ROW_W - 1) / slt_pkg::ROW_W;
    localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_W    = $clog2(SLOT_COUNT);

    logic                      bm_we;
    logic [ROW_IDX_W-1:0]      bm_waddr;
    logic [slt_pkg::ROW_W-1:0] bm_wdata;
    logic [ROW_IDX_W-1:0]      bm_raddr;
    logic [slt_pkg::ROW_W-1:0] bm_rdata;
    logic                      vm_we;
    logic [SLOT_W-1:0]         vm_waddr;
    logic [VALUE_WIDTH-1:0]    vm_wdata;
    logic [SLOT_W-1:0]         vm_raddr;
    logic [VALUE_WIDTH-1:0]    vm_rdata;
    slt_pkg::flag_upd_t        upd;
    logic [ROW_IDX_W-1:0]      upd_row;
    logic                      srch_found;
    logic [ROW_IDX_W-1:0]      srch_row;

    slt_ctrl #(
        .SLOT_COUNT  (SLOT_COUNT),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .bm_we      (bm_we),
        .bm_waddr   (bm_waddr),
        .bm_wdata   (bm_wdata),
        .bm_raddr   (bm_raddr),
        .bm_rdata   (bm_rdata),
        .vm_we      (vm_we),
        .vm_waddr   (vm_waddr),
        .vm_wdata   (vm_wdata),
        .vm_raddr   (vm_raddr),
        .vm_rdata   (vm_rdata),
        .upd        (upd),
        .upd_row    (upd_row),
        .srch_found (srch_found),
        .srch_row   (srch_row)
    );

    slt_ram #(
        .WIDTH  (slt_pkg::ROW_W),
        .DEPTH  (ROWS),
        .ADDR_W (ROW_IDX_W)
    ) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    slt_ram #(
        .WIDTH  (VALUE_WIDTH),
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (SLOT_W)
    ) u_values (
        .clk   (clk),
        .we    (vm_we),
        .waddr (vm_waddr),
        .wdata (vm_wdata),
        .raddr (vm_raddr),
        .rdata (vm_rdata)
    );

    slt_search #(
        .ROWS      (ROWS),
        .ROW_IDX_W (ROW_IDX_W)
    ) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (upd),
        .upd_row  (upd_row),
        .found    (srch_found),
        .free_row (srch_row)
    );

endmodule

@@ rtl/slt_checker.sv @@
// Port-level checks of the slot table allocator, bound to the top level.
// Depends on slt_pkg and on the top level slot_table_allocator.
module slt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic                           rsp_ok,
    input logic [slt_pkg::IDX_W-1:0]      rsp_slot,
    input logic [slt_pkg::VAL_PORT_W-1:0] rsp_value,
    input logic [slt_pkg::ERR_W-1:0]      rsp_error
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       req_beat;
    logic       rsp_beat;

    assign req_beat = req_valid && req_ready;
    assign rsp_beat = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (req_beat && !rsp_beat)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (rsp_beat && !req_beat)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A response beat must answer a request beat that came before it.
    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_beat |-> pending_reg != 2'd0)
        else $error("response beat without an outstanding request");

    // One request in work and one response waiting is the most the block holds.
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two requests outstanding");

    a_result_coherent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_ok == (rsp_error == slt_pkg::ERR_NONE)) &&
                      (rsp_ok || (rsp_slot == '0 && rsp_value == '0)))
        else $error("response fields disagree with the ok flag");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid &&
            $stable({rsp_ok, rsp_slot, rsp_value, rsp_error}))
        else $error("stalled response beat changed");

endmodule

bind slot_table_allocator slt_checker u_slt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_ok    (rsp.ok),
    .rsp_slot  (rsp.slot_out),
    .rsp_value (rsp.value_out),
    .rsp_error (rsp.error_code)
);

@@ verif/tb.sv @@
// Testbench for slot_table_allocator: drives alloc, free, set and get beats with random
// gaps and stalls and checks every response against a shadow copy of the slot table.
// Depends on slt_pkg and the slt_req_if / slt_rsp_if channel interfaces.
`timescale 1ns / 100ps

module tb;

    localparam int NSLOTS      = slt_pkg::SLOT_COUNT_DEF;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_AFTER  = 40;
    localparam int HOLD_CYCLES = 300;

    class slot_table_tracker;
        bit                             busy [NSLOTS];
        logic [slt_pkg::VAL_PORT_W-1:0] stored [NSLOTS];
        int                             bump;
        int                             busy_count;
        slt_pkg::result_t               due_results [$];
        int                             mismatches;

        function new();
            bump = 0;
            busy_count = 0;
            mismatches = 0;
            foreach (busy[i])
            begin
                busy[i] = 1'b0;
            end
        endfunction

        function void record_request(slt_pkg::action_t op, logic [slt_pkg::IDX_W-1:0] idx,
                                     logic [slt_pkg::VAL_PORT_W-1:0] data);
            slt_pkg::result_t res;
            int               grant;
            int               i;
            res = '0;
            if (op == slt_pkg::ACT_ALLOC)
            begin
                grant = -1;
                while (bump < NSLOTS && grant < 0)
                begin
                    if (!busy[bump])
                    begin
                        grant = bump;
                    end
                    bump++;
                end
                for (i = 0; i < NSLOTS && grant < 0; i++)
                begin
                    if (!busy[i])
                    begin
                        grant = i;
                    end
                end
                if (grant < 0)
                begin
                    res.err = slt_pkg::ERR_FULL;
                end
                else
                begin
                    busy[grant] = 1'b1;
                    busy_count++;
                    stored[grant] = '0;
                    res.ok = 1'b1;
                    res.slot = grant[slt_pkg::IDX_W-1:0];
                end
            end
            else if (int'(idx) >= bump || !busy[idx])
            begin
                res.err = slt_pkg::ERR_INVALID;
            end
            else
            begin
                res.ok = 1'b1;
                case (op)
                    slt_pkg::ACT_FREE:
                    begin
                        busy[idx] = 1'b0;
                        busy_count--;
                    end
                    slt_pkg::ACT_SET:
                    begin
                        stored[idx] = data;
                    end
                    default:
                    begin
                        res.value = stored[idx];
                    end
                endcase
            end
            due_results = {due_results, res};
        endfunction

        function void compare_response(logic ok, logic [slt_pkg::IDX_W-1:0] slot,
                                       logic [slt_pkg::VAL_PORT_W-1:0] value,
                                       logic [slt_pkg::ERR_W-1:0] err);
            slt_pkg::result_t want;
            if (due_results.size() == 0)
            begin
                $error("response beat arrived with no request outstanding");
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (ok !== want.ok)
            begin
                $error("ok: expected %0d, got %0d", want.ok, ok);
                mismatches++;
            end
            if (slot !== want.slot)
            begin
                $error("slot_out: expected %0d, got %0d", want.slot, slot);
                mismatches++;
            end
            if (value !== want.value)
            begin
                $error("value_out: expected %h, got %h", want.value, value);
                mismatches++;
            end
            if (err !== want.err)
            begin
                $error("error_code: expected %0d, got %0d", want.err, err);
                mismatches++;
            end
        endfunction

        function int pick_busy();
            int start;
            int k;
            int j;
            if (bump == 0)
            begin
                return -1;
            end
            start = $urandom_range(0, bump - 1);
            for (k = 0; k < bump; k++)
            begin
                j = (start + k) % bump;
                if (busy[j])
                begin
                    return j;
                end
            end
            return -1;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   idle_cycles;
    int   sent;
    bit   send_burst;
    int   rsp_beats;
    bit   rsp_burst;

    slot_table_tracker tracker = new();

    slt_req_if req_ch ();
    slt_rsp_if rsp_ch ();

    slot_table_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic logic [slt_pkg::VAL_PORT_W-1:0] rand_value();
        logic [slt_pkg::VAL_PORT_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2: v = {{(slt_pkg::VAL_PORT_W-1){1'b0}}, 1'b1} <<
                   $urandom_range(0, slt_pkg::VAL_PORT_W - 1);
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic [slt_pkg::IDX_W-1:0] rand_index();
        return slt_pkg::IDX_W'($urandom_range(0, NSLOTS - 1));
    endfunction

    task automatic send_beat(input slt_pkg::action_t op,
                             input logic [slt_pkg::IDX_W-1:0] idx,
                             input logic [slt_pkg::VAL_PORT_W-1:0] data);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= op;
        req_ch.slot_index <= idx;
        req_ch.value_in   <= data;
        do
            @(posedge clk);
        while (!req_ch.ready);
        tracker.record_request(op, idx, data);
        sent++;
        if (sent % 64 == 0)
        begin
            send_burst = ($urandom_range(0, 3) == 0);
        end
        @(negedge clk);
    endtask

    task automatic run_mixed(input int count, input int alloc_pct);
        slt_pkg::action_t op;
        int               target;
        int               idx;
        int               n;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < alloc_pct)
            begin
                op = slt_pkg::ACT_ALLOC;
            end
            else
            begin
                op = slt_pkg::action_t'($urandom_range(1, 3));
            end
            target = tracker.pick_busy();
            if (op == slt_pkg::ACT_ALLOC || target < 0 || $urandom_range(0, 3) == 0)
            begin
                idx = $urandom_range(0, NSLOTS - 1);
            end
            else
            begin
                idx = target;
            end
            send_beat(op, idx[slt_pkg::IDX_W-1:0], rand_value());
        end
    endtask

    task automatic fill_table();
        int target;
        int n;
        while (tracker.busy_count < NSLOTS)
        begin
            target = tracker.pick_busy();
            if (target >= 0 && $urandom_range(0, 4) == 0)
            begin
                send_beat($urandom_range(0, 1) ? slt_pkg::ACT_SET : slt_pkg::ACT_GET,
                          target[slt_pkg::IDX_W-1:0], rand_value());
            end
            else
            begin
                send_beat(slt_pkg::ACT_ALLOC, rand_index(), rand_value());
            end
        end
        for (n = 0; n < 4; n++)
        begin
            send_beat(slt_pkg::ACT_ALLOC, rand_index(), rand_value());
        end
    endtask

    task automatic run_directed();
        send_beat(slt_pkg::ACT_GET, 10'd0, '0);
        send_beat(slt_pkg::ACT_FREE, 10'd1023, '0);
        send_beat(slt_pkg::ACT_ALLOC, 10'd0, '0);
        send_beat(slt_pkg::ACT_GET, 10'd0, '1);
        send_beat(slt_pkg::ACT_SET, 10'd0, '1);
        send_beat(slt_pkg::ACT_GET, 10'd0, '0);
        send_beat(slt_pkg::ACT_ALLOC, 10'd1023, '1);
        send_beat(slt_pkg::ACT_SET, 10'd1, 64'h5555_5555_5555_5555);
        send_beat(slt_pkg::ACT_GET, 10'd1, '0);
        send_beat(slt_pkg::ACT_SET, 10'd1, 64'hAAAA_AAAA_AAAA_AAAA);
        send_beat(slt_pkg::ACT_GET, 10'd1, '1);
        send_beat(slt_pkg::ACT_FREE, 10'd0, '0);
        send_beat(slt_pkg::ACT_GET, 10'd0, '0);
        send_beat(slt_pkg::ACT_FREE, 10'd0, '0);
        send_beat(slt_pkg::ACT_SET, 10'd0, 64'h1234_5678_9ABC_DEF0);
        send_beat(slt_pkg::ACT_SET, 10'd2, '1);
        send_beat(slt_pkg::ACT_ALLOC, 10'd0, '0);
        send_beat(slt_pkg::ACT_GET, 10'd2, '0);
        send_beat(slt_pkg::ACT_FREE, 10'd1, '0);
        send_beat(slt_pkg::ACT_ALLOC, 10'd512, '0);
        send_beat(slt_pkg::ACT_GET, 10'd1023, '0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.action = slt_pkg::ACT_ALLOC;
        req_ch.slot_index = '0;
        req_ch.value_in = '0;
        sent = 0;
        send_burst = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_directed();
        run_mixed(250, 35);
        fill_table();
        run_mixed(250, 30);
        req_ch.valid <= 1'b0;
        while (tracker.due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        if (tracker.mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // The receiver holds off once for a long stretch so that the block backs up.
    initial
    begin
        int gap;
        rsp_ch.ready = 1'b0;
        rsp_beats = 0;
        rsp_burst = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (rsp_beats == HOLD_AFTER)
            begin
                gap = HOLD_CYCLES;
            end
            else
            begin
                gap = rsp_burst ? 0 : $urandom_range(0, 6);
            end
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            tracker.compare_response(rsp_ch.ok, rsp_ch.slot_out, rsp_ch.value_out,
                                     rsp_ch.error_code);
            rsp_beats++;
            if (rsp_beats % 64 == 0)
            begin
                rsp_burst = ($urandom_range(0, 3) == 0);
            end
            @(negedge clk);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
